/* src/tcu_pkg.sv */
package tcu_pkg;

  // Fixed point format of positions and directions
  localparam int FRAC_BITS    = 16;
  localparam int SQRT_STEPS   = 64;
  localparam int QUO_BITS     = 63;
  localparam int CORDIC_STEPS = 30;

  // 1.0 squared, fade threshold (fall-off plus one) and fade ceiling
  localparam logic [63:0] ONE_SQ   = 64'(1) << (2 * FRAC_BITS);
  localparam logic [63:0] FADE_THR = 64'(7) << FRAC_BITS;
  localparam logic [63:0] FADE_ONE = 64'(1) << FRAC_BITS;
  localparam int          FADE_R   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int          FADE_L   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  // Offset magnitude cap
  localparam logic [62:0] OFF_CAP = 63'(1) << 62;

  // floor(x / 3) = (x * DIV3_MUL) >> DIV3_SH for x below 2^34
  localparam logic [33:0] DIV3_MUL = 34'd11453246123;
  localparam int          DIV3_SH  = 35;

  // Register indexes
  localparam logic [1:0] CFG_EYE_X = 2'd0;
  localparam logic [1:0] CFG_EYE_Y = 2'd1;
  localparam logic [1:0] CFG_EYE_Z = 2'd2;

  typedef struct packed {
    logic signed [31:0] ray_x;
    logic signed [31:0] ray_y;
    logic signed [31:0] ray_z;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] turn_u;
    logic signed [31:0] depth_v;
    logic [16:0]        fade;
  } out_t;

  // Quadratic terms handed from setup to the root stages
  typedef struct packed {
    in_t         ray;
    logic [63:0] a;
    logic [63:0] hmag;
    logic        hneg;
    logic        eye_in;
    logic        miss;
  } quad_t;

  // Hit point handed to the angle stages
  typedef struct packed {
    logic               miss;
    logic signed [63:0] px;
    logic signed [63:0] py;
    logic signed [63:0] pz;
    logic signed [63:0] dz;
  } pos_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

/* src/tcu_quad.sv */
module tcu_quad (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  tcu_pkg::in_t       in_item,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  output logic               o_v,
  output tcu_pkg::quad_t     o_side,
  output logic [127:0]       o_rad
);

  // stage A: squares and dot products
  logic               v_a_r;
  tcu_pkg::in_t       ray_a_r;
  logic signed [63:0] rxx_a_r, ryy_a_r, rxe_a_r, rye_a_r, exx_a_r, eyy_a_r;
  // stage B: sums
  logic               v_b_r;
  tcu_pkg::in_t       ray_b_r;
  logic [63:0]        a_b_r, s_b_r;
  logic signed [64:0] h_b_r;
  logic               az_b_r;
  // stage C: magnitudes
  logic               v_c_r;
  tcu_pkg::quad_t     side_c_r;
  logic [63:0]        cmag_c_r;
  logic [63:0]        hmag_nxt, cmag_nxt;
  logic               inside_nxt;
  // stage D: partial products
  logic               v_d_r;
  tcu_pkg::quad_t     side_d_r;
  logic [63:0]        hll_d_r, hlh_d_r, hhh_d_r, alcl_d_r, alch_d_r, ahcl_d_r, ahch_d_r;
  // stage E: h^2 and a*c
  logic               v_e_r;
  tcu_pkg::quad_t     side_e_r;
  logic [127:0]       h2_e_r, ac_e_r;
  // stage F: discriminant
  logic               v_f_r;
  tcu_pkg::quad_t     side_f_r;
  tcu_pkg::quad_t     side_f_nxt;
  logic [127:0]       d_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_e_r <= 1'b0;
      v_f_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_v;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
      v_d_r <= v_c_r;
      v_e_r <= v_d_r;
      v_f_r <= v_e_r;
    end
  end

  always_comb begin
    hmag_nxt   = h_b_r[64] ? 64'(-h_b_r) : h_b_r[63:0];
    inside_nxt = s_b_r < tcu_pkg::ONE_SQ;
    cmag_nxt   = inside_nxt ? tcu_pkg::ONE_SQ - s_b_r : s_b_r - tcu_pkg::ONE_SQ;
  end

  // outside with h^2 < a*c has no real root
  always_comb begin
    side_f_nxt      = side_e_r;
    side_f_nxt.miss = side_e_r.miss || (!side_e_r.eye_in && (h2_e_r < ac_e_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // A
      ray_a_r <= in_item;
      rxx_a_r <= in_item.ray_x * in_item.ray_x;
      ryy_a_r <= in_item.ray_y * in_item.ray_y;
      rxe_a_r <= in_item.ray_x * eye_x;
      rye_a_r <= in_item.ray_y * eye_y;
      exx_a_r <= eye_x * eye_x;
      eyy_a_r <= eye_y * eye_y;
      // B
      ray_b_r <= ray_a_r;
      a_b_r   <= $unsigned(rxx_a_r) + $unsigned(ryy_a_r);
      s_b_r   <= $unsigned(exx_a_r) + $unsigned(eyy_a_r);
      h_b_r   <= 65'(rxe_a_r) + 65'(rye_a_r);
      az_b_r  <= (rxx_a_r == '0) && (ryy_a_r == '0);
      // C
      side_c_r.ray    <= ray_b_r;
      side_c_r.a      <= a_b_r;
      side_c_r.hmag   <= hmag_nxt;
      side_c_r.hneg   <= h_b_r[64];
      side_c_r.eye_in <= inside_nxt;
      side_c_r.miss   <= az_b_r;
      cmag_c_r        <= cmag_nxt;
      // D
      side_d_r <= side_c_r;
      hll_d_r  <= {32'b0, side_c_r.hmag[31:0]} * {32'b0, side_c_r.hmag[31:0]};
      hlh_d_r  <= {32'b0, side_c_r.hmag[31:0]} * {32'b0, side_c_r.hmag[63:32]};
      hhh_d_r  <= {32'b0, side_c_r.hmag[63:32]} * {32'b0, side_c_r.hmag[63:32]};
      alcl_d_r <= {32'b0, side_c_r.a[31:0]} * {32'b0, cmag_c_r[31:0]};
      alch_d_r <= {32'b0, side_c_r.a[31:0]} * {32'b0, cmag_c_r[63:32]};
      ahcl_d_r <= {32'b0, side_c_r.a[63:32]} * {32'b0, cmag_c_r[31:0]};
      ahch_d_r <= {32'b0, side_c_r.a[63:32]} * {32'b0, cmag_c_r[63:32]};
      // E
      side_e_r <= side_d_r;
      h2_e_r   <= {hhh_d_r, hll_d_r} + ({64'b0, hlh_d_r} << 33);
      ac_e_r   <= {ahch_d_r, alcl_d_r} + ({64'b0, alch_d_r} << 32)
                  + ({64'b0, ahcl_d_r} << 32);
      // F
      side_f_r <= side_f_nxt;
      d_f_r    <= side_e_r.eye_in ? h2_e_r + ac_e_r : h2_e_r - ac_e_r;
    end
  end

  assign o_v    = v_f_r;
  assign o_side = side_f_r;
  assign o_rad  = d_f_r;

endmodule

/* src/tcu_isqrt.sv */
module tcu_isqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  tcu_pkg::quad_t in_side,
  input  logic [127:0]   in_rad,
  output logic           o_v,
  output tcu_pkg::quad_t o_side,
  output logic [63:0]    o_root
);

  // One result bit per stage, two radicand bits consumed per stage
  logic           v_r    [tcu_pkg::SQRT_STEPS];
  tcu_pkg::quad_t side_r [tcu_pkg::SQRT_STEPS];
  logic [127:0]   rad_r  [tcu_pkg::SQRT_STEPS];
  logic [67:0]    rem_r  [tcu_pkg::SQRT_STEPS];
  logic [63:0]    root_r [tcu_pkg::SQRT_STEPS];

  for (genvar k = 0; k < tcu_pkg::SQRT_STEPS; k++) begin : g_step
    logic           v_p;
    tcu_pkg::quad_t side_p;
    logic [127:0]   rad_p;
    logic [67:0]    rem_p, rem_sh, trial, rem_nxt;
    logic [63:0]    root_p, root_nxt;
    logic           ge;

    if (k == 0) begin : g_first
      assign v_p    = in_v;
      assign side_p = in_side;
      assign rad_p  = in_rad;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign v_p    = v_r[k-1];
      assign side_p = side_r[k-1];
      assign rad_p  = rad_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
    end

    always_comb begin
      rem_sh   = {rem_p[65:0], rad_p[127:126]};
      trial    = {2'b0, root_p, 2'b01};
      ge       = rem_sh >= trial;
      rem_nxt  = ge ? rem_sh - trial : rem_sh;
      root_nxt = {root_p[62:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_p;
        rad_r[k]  <= rad_p << 2;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
      end
    end
  end

  assign o_v    = v_r[tcu_pkg::SQRT_STEPS-1];
  assign o_side = side_r[tcu_pkg::SQRT_STEPS-1];
  assign o_root = root_r[tcu_pkg::SQRT_STEPS-1];

endmodule

/* src/tcu_offs.sv */
module tcu_offs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  tcu_pkg::quad_t     in_side,
  input  logic [63:0]        in_root,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  output logic               o_v,
  output tcu_pkg::pos_t      o_pos
);

  typedef struct packed {
    logic [63:0] a;
    logic [2:0]  neg;
    logic        miss;
  } dside_t;

  // G1: root plus h terms
  logic           v_g1_r;
  tcu_pkg::quad_t side_g1_r;
  logic [64:0]    pw_g1_r, qw_g1_r;
  logic [63:0]    hp, hn;
  logic [64:0]    sum_nxt;
  // G2: numerator and ray magnitudes
  logic           v_g2_r;
  dside_t         side_g2_r;
  logic [64:0]    n_g2_r;
  logic [31:0]    mag_g2_r [3];
  // H: partial products
  logic           v_h_r;
  dside_t         side_h_r;
  logic [63:0]    lo_h_r [3];
  logic [64:0]    hi_h_r [3];
  // I: full products
  logic           v_i_r;
  dside_t         side_i_r;
  logic [96:0]    p_i_r [3];
  // J: divider setup
  logic           v_j_r;
  dside_t         side_j_r;
  logic [2:0]     sat_j_r;
  logic [63:0]    rem_j_r [3];
  logic [62:0]    low_j_r [3];
  // divider steps
  logic           v_q_r    [tcu_pkg::QUO_BITS];
  dside_t         side_q_r [tcu_pkg::QUO_BITS];
  logic [2:0]     sat_q_r  [tcu_pkg::QUO_BITS];
  logic [63:0]    rem_q_r  [tcu_pkg::QUO_BITS][3];
  logic [62:0]    low_q_r  [tcu_pkg::QUO_BITS][3];
  logic [62:0]    quo_q_r  [tcu_pkg::QUO_BITS][3];
  // K1: signed offsets
  logic               v_k1_r;
  logic               miss_k1_r;
  logic signed [63:0] off_k1_r [3];
  // K2: hit point
  logic           v_k2_r;
  tcu_pkg::pos_t  pos_k2_r;

  always_comb begin
    hp      = in_side.hneg ? 64'b0 : in_side.hmag;
    hn      = in_side.hneg ? in_side.hmag : 64'b0;
    sum_nxt = {1'b0, in_root} + {1'b0, (in_side.eye_in ? hn : hp)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_g1_r <= 1'b0;
      v_g2_r <= 1'b0;
      v_h_r  <= 1'b0;
      v_i_r  <= 1'b0;
      v_j_r  <= 1'b0;
      v_k1_r <= 1'b0;
      v_k2_r <= 1'b0;
    end else if (en) begin
      v_g1_r <= in_v;
      v_g2_r <= v_g1_r;
      v_h_r  <= v_g2_r;
      v_i_r  <= v_h_r;
      v_j_r  <= v_i_r;
      v_k1_r <= v_q_r[tcu_pkg::QUO_BITS-1];
      v_k2_r <= v_k1_r;
    end
  end

  // far root inside the cylinder, near root otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      side_g1_r <= in_side;
      pw_g1_r   <= in_side.eye_in ? sum_nxt : {1'b0, hn};
      qw_g1_r   <= in_side.eye_in ? {1'b0, hp} : sum_nxt;

      side_g2_r.a    <= side_g1_r.a;
      side_g2_r.neg  <= {side_g1_r.ray.ray_z[31], side_g1_r.ray.ray_y[31],
                         side_g1_r.ray.ray_x[31]};
      side_g2_r.miss <= side_g1_r.miss || (pw_g1_r < qw_g1_r);
      n_g2_r         <= pw_g1_r - qw_g1_r;
      mag_g2_r[0]    <= side_g1_r.ray.ray_x[31] ? 32'(-side_g1_r.ray.ray_x)
                                                : side_g1_r.ray.ray_x;
      mag_g2_r[1]    <= side_g1_r.ray.ray_y[31] ? 32'(-side_g1_r.ray.ray_y)
                                                : side_g1_r.ray.ray_y;
      mag_g2_r[2]    <= side_g1_r.ray.ray_z[31] ? 32'(-side_g1_r.ray.ray_z)
                                                : side_g1_r.ray.ray_z;

      side_h_r <= side_g2_r;
      side_i_r <= side_h_r;
      side_j_r <= side_i_r;
    end
  end

  // per-lane products and divider setup
  for (genvar l = 0; l < 3; l++) begin : g_lane
    always_ff @(posedge clk) begin
      if (en) begin
        lo_h_r[l]  <= {32'b0, n_g2_r[31:0]} * {32'b0, mag_g2_r[l]};
        hi_h_r[l]  <= {32'b0, n_g2_r[64:32]} * {33'b0, mag_g2_r[l]};
        p_i_r[l]   <= {hi_h_r[l], 32'b0} + {33'b0, lo_h_r[l]};
        // quotient of 2^63 or more saturates anyway
        sat_j_r[l] <= {30'b0, p_i_r[l][96:63]} >= side_i_r.a;
        rem_j_r[l] <= {30'b0, p_i_r[l][96:63]};
        low_j_r[l] <= p_i_r[l][62:0];
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < tcu_pkg::QUO_BITS; k++) begin : g_div
    logic       v_p;
    dside_t     side_p;
    logic [2:0] sat_p;
    logic [63:0] rem_p [3];
    logic [62:0] low_p [3];
    logic [62:0] quo_p [3];

    if (k == 0) begin : g_first
      assign v_p    = v_j_r;
      assign side_p = side_j_r;
      assign sat_p  = sat_j_r;
      for (genvar l = 0; l < 3; l++) begin : g_l
        assign rem_p[l] = rem_j_r[l];
        assign low_p[l] = low_j_r[l];
        assign quo_p[l] = '0;
      end
    end else begin : g_next
      assign v_p    = v_q_r[k-1];
      assign side_p = side_q_r[k-1];
      assign sat_p  = sat_q_r[k-1];
      for (genvar l = 0; l < 3; l++) begin : g_l
        assign rem_p[l] = rem_q_r[k-1][l];
        assign low_p[l] = low_q_r[k-1][l];
        assign quo_p[l] = quo_q_r[k-1][l];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_q_r[k] <= 1'b0;
      end else if (en) begin
        v_q_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q_r[k] <= side_p;
        sat_q_r[k]  <= sat_p;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [64:0] rem_sh;
      logic        ge;

      always_comb begin
        rem_sh = {rem_p[l], low_p[l][62]};
        ge     = rem_sh >= {1'b0, side_p.a};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q_r[k][l] <= ge ? 64'(rem_sh - {1'b0, side_p.a}) : rem_sh[63:0];
          low_q_r[k][l] <= low_p[l] << 1;
          quo_q_r[k][l] <= {quo_p[l][61:0], ge};
        end
      end
    end
  end

  // saturate, apply sign of the ray component
  for (genvar l = 0; l < 3; l++) begin : g_off
    logic [62:0] qf;

    always_comb begin
      if (sat_q_r[tcu_pkg::QUO_BITS-1][l]
          || (quo_q_r[tcu_pkg::QUO_BITS-1][l] > tcu_pkg::OFF_CAP)) begin
        qf = tcu_pkg::OFF_CAP;
      end else begin
        qf = quo_q_r[tcu_pkg::QUO_BITS-1][l];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        off_k1_r[l] <= side_q_r[tcu_pkg::QUO_BITS-1].neg[l] ? -$signed({1'b0, qf})
                                                            : $signed({1'b0, qf});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      miss_k1_r     <= side_q_r[tcu_pkg::QUO_BITS-1].miss;
      pos_k2_r.miss <= miss_k1_r;
      pos_k2_r.px   <= 64'(eye_x) + off_k1_r[0];
      pos_k2_r.py   <= 64'(eye_y) + off_k1_r[1];
      pos_k2_r.pz   <= 64'(eye_z) + off_k1_r[2];
      pos_k2_r.dz   <= off_k1_r[2];
    end
  end

  assign o_v   = v_k2_r;
  assign o_pos = pos_k2_r;

endmodule

/* src/tcu_angle.sv */
module tcu_angle (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  tcu_pkg::pos_t in_pos,
  output logic          o_v,
  output tcu_pkg::out_t o_item
);

  typedef struct packed {
    logic               miss;
    logic               vx_neg;
    logic               vy_neg;
    logic               mzero;
    logic signed [31:0] depth;
    logic [16:0]        fade;
  } aside_t;

  // P0: magnitudes
  logic        v_p0_r, miss_p0_r, vxn_p0_r, vyn_p0_r, pzn_p0_r;
  logic [63:0] bx_p0_r, by_p0_r, zm_p0_r, zd_p0_r;
  // P1: fade, depth product, first normalize steps
  logic        v_p1_r, miss_p1_r, vxn_p1_r, vyn_p1_r, pzn_p1_r, big_p1_r, mz_p1_r;
  logic [16:0] fade_p1_r;
  logic [66:0] prod_p1_r;
  logic [63:0] bx_p1_r, by_p1_r;
  // P2: depth, more normalize steps
  logic        v_p2_r;
  aside_t      side_p2_r;
  logic [63:0] bx_p2_r, by_p2_r;
  // P3: CORDIC start vector
  logic        v_p3_r;
  aside_t      side_p3_r;
  logic [29:0] x0_p3_r, y0_p3_r;
  // CORDIC
  logic               v_c_r    [tcu_pkg::CORDIC_STEPS];
  aside_t             side_c_r [tcu_pkg::CORDIC_STEPS];
  logic signed [33:0] x_c_r    [tcu_pkg::CORDIC_STEPS];
  logic signed [33:0] y_c_r    [tcu_pkg::CORDIC_STEPS];
  logic signed [33:0] z_c_r    [tcu_pkg::CORDIC_STEPS];
  // F1: angle in half-turn terms
  logic        v_f1_r;
  aside_t      side_f1_r;
  logic [31:0] theta_f1_r;
  // F2: output register
  logic          v_f2_r;
  tcu_pkg::out_t item_f2_r;

  logic [64:0]        fdiff;
  logic [tcu_pkg::FRAC_BITS:0] fclamp;
  logic [32:0]        fw;
  logic [16:0]        fade_nxt;
  logic [63:0]        m0, bx_a, by_a, m_a, bx_b, by_b;
  logic [63:0]        m1, bx_c, by_c, m_c, bx_d, by_d;
  logic [63:0]        m2, bx_e, by_e, m_e, bx_f, by_f;
  logic [31:0]        dq;
  logic signed [31:0] depth_nxt;
  logic signed [33:0] zl;
  logic [30:0]        phi;
  logic [32:0]        tsum;
  logic [15:0]        t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_p0_r <= 1'b0;
      v_p1_r <= 1'b0;
      v_p2_r <= 1'b0;
      v_p3_r <= 1'b0;
      v_f1_r <= 1'b0;
      v_f2_r <= 1'b0;
    end else if (en) begin
      v_p0_r <= in_v;
      v_p1_r <= v_p0_r;
      v_p2_r <= v_p1_r;
      v_p3_r <= v_p2_r;
      v_f1_r <= v_c_r[tcu_pkg::CORDIC_STEPS-1];
      v_f2_r <= v_f1_r;
    end
  end

  // fade clamp and first two normalize shifts
  always_comb begin
    fdiff  = {1'b0, zd_p0_r} - {1'b0, tcu_pkg::FADE_THR};
    if (zd_p0_r <= tcu_pkg::FADE_THR) begin
      fclamp = '0;
    end else if (fdiff[63:0] > tcu_pkg::FADE_ONE) begin
      fclamp = tcu_pkg::FADE_ONE[tcu_pkg::FRAC_BITS:0];
    end else begin
      fclamp = fdiff[tcu_pkg::FRAC_BITS:0];
    end
    fw       = 33'(fclamp);
    fade_nxt = (tcu_pkg::FRAC_BITS >= 16) ? 17'(fw >> tcu_pkg::FADE_R)
                                          : 17'(fw << tcu_pkg::FADE_L);

    m0   = bx_p0_r | by_p0_r;
    bx_a = (m0[63:32] == '0) ? bx_p0_r << 32 : bx_p0_r;
    by_a = (m0[63:32] == '0) ? by_p0_r << 32 : by_p0_r;
    m_a  = bx_a | by_a;
    bx_b = (m_a[63:48] == '0) ? bx_a << 16 : bx_a;
    by_b = (m_a[63:48] == '0) ? by_a << 16 : by_a;
  end

  // depth saturation and normalize shifts by 8 and 4
  always_comb begin
    dq = prod_p1_r[66:tcu_pkg::DIV3_SH];
    if (pzn_p1_r) begin
      depth_nxt = (big_p1_r || dq > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(dq);
    end else begin
      depth_nxt = (big_p1_r || dq > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(dq);
    end

    m1   = bx_p1_r | by_p1_r;
    bx_c = (m1[63:56] == '0) ? bx_p1_r << 8 : bx_p1_r;
    by_c = (m1[63:56] == '0) ? by_p1_r << 8 : by_p1_r;
    m_c  = bx_c | by_c;
    bx_d = (m_c[63:60] == '0) ? bx_c << 4 : bx_c;
    by_d = (m_c[63:60] == '0) ? by_c << 4 : by_c;
  end

  // last normalize shifts by 2 and 1
  always_comb begin
    m2   = bx_p2_r | by_p2_r;
    bx_e = (m2[63:62] == '0) ? bx_p2_r << 2 : bx_p2_r;
    by_e = (m2[63:62] == '0) ? by_p2_r << 2 : by_p2_r;
    m_e  = bx_e | by_e;
    bx_f = (m_e[63] == 1'b0) ? bx_e << 1 : bx_e;
    by_f = (m_e[63] == 1'b0) ? by_e << 1 : by_e;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // P0
      miss_p0_r <= in_pos.miss;
      vxn_p0_r  <= in_pos.px[63];
      vyn_p0_r  <= in_pos.py[63];
      pzn_p0_r  <= in_pos.pz[63];
      bx_p0_r   <= in_pos.py[63] ? 64'(-in_pos.py) : in_pos.py;
      by_p0_r   <= in_pos.px[63] ? 64'(-in_pos.px) : in_pos.px;
      zm_p0_r   <= in_pos.pz[63] ? 64'(-in_pos.pz) : in_pos.pz;
      zd_p0_r   <= in_pos.dz[63] ? 64'(-in_pos.dz) : in_pos.dz;
      // P1: depth = floor((|pz| >> 1) / 3)
      miss_p1_r <= miss_p0_r;
      vxn_p1_r  <= vxn_p0_r;
      vyn_p1_r  <= vyn_p0_r;
      pzn_p1_r  <= pzn_p0_r;
      big_p1_r  <= zm_p0_r[63:34] != '0;
      mz_p1_r   <= (bx_p0_r | by_p0_r) == '0;
      prod_p1_r <= {34'b0, zm_p0_r[33:1]} * {33'b0, tcu_pkg::DIV3_MUL};
      fade_p1_r <= fade_nxt;
      bx_p1_r   <= bx_b;
      by_p1_r   <= by_b;
      // P2
      side_p2_r.miss   <= miss_p1_r;
      side_p2_r.vx_neg <= vxn_p1_r;
      side_p2_r.vy_neg <= vyn_p1_r;
      side_p2_r.mzero  <= mz_p1_r;
      side_p2_r.depth  <= depth_nxt;
      side_p2_r.fade   <= fade_p1_r;
      bx_p2_r          <= bx_d;
      by_p2_r          <= by_d;
      // P3: leading one now at bit 29
      side_p3_r <= side_p2_r;
      x0_p3_r   <= bx_f[63:34];
      y0_p3_r   <= by_f[63:34];
    end
  end

  // CORDIC vectoring, stops once y reaches zero
  for (genvar i = 0; i < tcu_pkg::CORDIC_STEPS; i++) begin : g_rot
    logic               v_p;
    aside_t             side_p;
    logic signed [33:0] x_p, y_p, z_p, x_nxt, y_nxt, z_nxt, ang;

    if (i == 0) begin : g_first
      assign v_p    = v_p3_r;
      assign side_p = side_p3_r;
      assign x_p    = $signed({4'b0, x0_p3_r});
      assign y_p    = $signed({4'b0, y0_p3_r});
      assign z_p    = '0;
    end else begin : g_next
      assign v_p    = v_c_r[i-1];
      assign side_p = side_c_r[i-1];
      assign x_p    = x_c_r[i-1];
      assign y_p    = y_c_r[i-1];
      assign z_p    = z_c_r[i-1];
    end

    assign ang = $signed({2'b0, tcu_pkg::atan_turn(i)});

    always_comb begin
      if (y_p == '0) begin
        x_nxt = x_p;
        y_nxt = y_p;
        z_nxt = z_p;
      end else if (!y_p[33]) begin
        x_nxt = x_p + (y_p >>> i);
        y_nxt = y_p - (x_p >>> i);
        z_nxt = z_p + ang;
      end else begin
        x_nxt = x_p - (y_p >>> i);
        y_nxt = y_p + (x_p >>> i);
        z_nxt = z_p - ang;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_c_r[i] <= 1'b0;
      end else if (en) begin
        v_c_r[i] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_c_r[i] <= side_p;
        x_c_r[i]    <= x_nxt;
        y_c_r[i]    <= y_nxt;
        z_c_r[i]    <= z_nxt;
      end
    end
  end

  // clamp to a quarter turn, fold into the lower half plane
  always_comb begin
    zl = z_c_r[tcu_pkg::CORDIC_STEPS-1];
    if (side_c_r[tcu_pkg::CORDIC_STEPS-1].mzero || zl[33]) begin
      phi = '0;
    end else if (zl > 34'sh4000_0000) begin
      phi = 31'h4000_0000;
    end else begin
      phi = zl[30:0];
    end
    tsum = {1'b0, theta_f1_r} + 33'h0_0001_0000;
    t    = 16'(tsum >> 17);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_f1_r  <= side_c_r[tcu_pkg::CORDIC_STEPS-1];
      theta_f1_r <= side_c_r[tcu_pkg::CORDIC_STEPS-1].vy_neg ? 32'h8000_0000 - {1'b0, phi}
                                                             : {1'b0, phi};
      if (side_f1_r.miss) begin
        item_f2_r <= '0;
      end else begin
        item_f2_r.hit     <= 1'b1;
        item_f2_r.turn_u  <= side_f1_r.vx_neg ? -$signed(t) : $signed(t);
        item_f2_r.depth_v <= side_f1_r.depth;
        item_f2_r.fade    <= side_f1_r.fade;
      end
    end
  end

  assign o_v    = v_f2_r;
  assign o_item = item_f2_r;

endmodule

/* src/tunnel_ray_cylinder_uv_unit.sv */
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall   tcu_pkg::in_t  (ray_x, ray_y, ray_z)
// out_     output     out_valid / out_stall tcu_pkg::out_t (hit, turn_u, depth_v, fade)
// cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data (eye_x, eye_y, eye_z)
//
// One item per clock while no result is held by out_stall; the longest parts are
// the 64-stage square root, the 63-stage offset divider and the 30-stage angle CORDIC.
// Synchronous active-low reset clears the valid bits and the eye registers.
// A stalled result freezes the whole pipeline; in_stall follows out_stall
// while out_valid is high. Configuration writes are always taken.
module tunnel_ray_cylinder_uv_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tcu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tcu_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  logic               en;
  logic signed [31:0] eye_x_r, eye_y_r, eye_z_r;
  logic               q_v, r_v, p_v;
  tcu_pkg::quad_t     q_side, r_side;
  logic [127:0]       q_rad;
  logic [63:0]        r_root;
  tcu_pkg::pos_t      p_pos;

  // pipeline advances unless a result is held
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // eye registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_x_r <= '0;
      eye_y_r <= '0;
      eye_z_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tcu_pkg::CFG_EYE_X: eye_x_r <= cfg_data;
        tcu_pkg::CFG_EYE_Y: eye_y_r <= cfg_data;
        tcu_pkg::CFG_EYE_Z: eye_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tcu_quad u_quad (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (in_valid),
    .in_item (in_data),
    .eye_x   (eye_x_r),
    .eye_y   (eye_y_r),
    .o_v     (q_v),
    .o_side  (q_side),
    .o_rad   (q_rad)
  );

  tcu_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (q_v),
    .in_side (q_side),
    .in_rad  (q_rad),
    .o_v     (r_v),
    .o_side  (r_side),
    .o_root  (r_root)
  );

  tcu_offs u_offs (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (r_v),
    .in_side (r_side),
    .in_root (r_root),
    .eye_x   (eye_x_r),
    .eye_y   (eye_y_r),
    .eye_z   (eye_z_r),
    .o_v     (p_v),
    .o_pos   (p_pos)
  );

  tcu_angle u_angle (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (p_v),
    .in_pos (p_pos),
    .o_v    (out_valid),
    .o_item (out_data)
  );

endmodule
